/* rtl/ole_pkg.sv */
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types, sizes and command codes of the ordered list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ole_pkg;

    localparam int CAPACITY    = 64;
    localparam int HANDLE_BITS = 16;
    localparam int KEY_BITS    = 32;
    localparam int POS_BITS    = 7;
    localparam int ST_BITS     = 3;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int ENTRY_W     = HANDLE_BITS + KEY_BITS;

    typedef enum logic [3:0] {
        K_INS_FRONT = 4'd0,
        K_INS_BACK  = 4'd1,
        K_INS_AT    = 4'd2,
        K_RM_FRONT  = 4'd3,
        K_RM_BACK   = 4'd4,
        K_RM_AT     = 4'd5,
        K_RM_HANDLE = 4'd6,
        K_FIND      = 4'd7,
        K_GET       = 4'd8,
        K_CLEAR     = 4'd9,
        K_SORT_UP   = 4'd10,
        K_SORT_DOWN = 4'd11
    } t_kind;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SH_CHK,
        S_SH_WR,
        S_RM_RD,
        S_RM_CAP,
        S_CL_CHK,
        S_CL_WR,
        S_FD_CHK,
        S_FD_CMP,
        S_SO_CHK,
        S_SO_TMP,
        S_SO_JCHK,
        S_SO_CMP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        RD_NONE, RD_I, RD_IM1, RD_IP1, RD_JM1
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE, WR_I_RDATA, WR_I_INPUT, WR_J_RDATA, WR_J_TEMP
    } t_wr_sel;

    typedef enum logic [2:0] {
        I_HOLD, I_SET_AT, I_SET_COUNT, I_ZERO, I_ONE, I_INC, I_DEC
    } t_i_op;

    typedef enum logic [1:0] {
        J_HOLD, J_SET_I, J_DEC
    } t_j_op;

    typedef enum logic [1:0] {
        CNT_HOLD, CNT_INC, CNT_DEC, CNT_ZERO
    } t_cnt_op;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_i_op   i_op;
        t_j_op   j_op;
        t_cnt_op cnt_op;
        logic    tmp_load;
        logic    capture;
        logic    set_st;
        t_status st;
        logic    finish;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  pos_ins_ok;
        logic  pos_ok;
        logic  full;
        logic  empty;
        logic  i_eq_at;
        logic  i_last;
        logic  i_ge_cnt;
        logic  j_zero;
        logic  match;
        logic  move;
        logic  out_free;
    } t_flags;

endpackage

`default_nettype wire

/* rtl/ole_ram.sv */
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/ole_datapath.sv */
// ----------------------------------------------------------------------------
// ole_datapath
// Entry store, index counters, operand and result registers of the list.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic [3:0]                      i_kind,
    input  wire logic [ole_pkg::HANDLE_BITS-1:0] i_item_handle,
    input  wire logic [ole_pkg::KEY_BITS-1:0]    i_item_key,
    input  wire logic [ole_pkg::POS_BITS-1:0]    i_position,
    input  wire ole_pkg::t_cmd                   i_cmd,
    output ole_pkg::t_flags                      o_flags,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ole_pkg::ST_BITS-1:0]          o_status,
    output logic [ole_pkg::HANDLE_BITS-1:0]      o_handle_out,
    output logic [ole_pkg::KEY_BITS-1:0]         o_key_out,
    output logic [ole_pkg::POS_BITS-1:0]         o_found_position,
    output logic [ole_pkg::POS_BITS-1:0]         o_entry_count,
    output logic                                 o_is_empty
);

    localparam int CW = ole_pkg::CNT_W;
    localparam int HB = ole_pkg::HANDLE_BITS;
    localparam int KB = ole_pkg::KEY_BITS;

    logic [3:0]                    r_kind;
    logic [HB-1:0]                 r_hin;
    logic [KB-1:0]                 r_kin;
    logic [CW-1:0]                 r_pos;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 r_i;
    logic [CW-1:0]                 r_j;
    logic [CW-1:0]                 r_at;
    logic [HB-1:0]                 r_th;
    logic [KB-1:0]                 r_tk;
    logic [HB-1:0]                 r_hout;
    logic [KB-1:0]                 r_kout;
    logic [CW-1:0]                 r_fpos;
    ole_pkg::t_status              r_st;
    logic                          r_out_valid;

    logic [CW-1:0]                 n_at;
    logic [CW-1:0]                 w_raddr;
    logic [CW-1:0]                 w_waddr;
    logic                          w_we;
    logic [ole_pkg::ENTRY_W-1:0]   w_wdata;
    logic [ole_pkg::ENTRY_W-1:0]   w_rdata;
    logic [HB-1:0]                 w_rh;
    logic [KB-1:0]                 w_rk;
    logic [CW-1:0]                 w_pos_in;

    assign w_rh     = w_rdata[ole_pkg::ENTRY_W-1:KB];
    assign w_rk     = w_rdata[KB-1:0];
    assign w_pos_in = CW'(i_position);

    // insert, remove and get point from the incoming kind, position and the present count
    always_comb begin
        case (i_kind)
            ole_pkg::K_INS_BACK: n_at = r_count;
            ole_pkg::K_RM_BACK:  n_at = r_count - CW'(1);
            ole_pkg::K_INS_AT, ole_pkg::K_RM_AT, ole_pkg::K_GET: n_at = w_pos_in - CW'(1);
            default:             n_at = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            ole_pkg::RD_IM1: w_raddr = r_i - CW'(1);
            ole_pkg::RD_IP1: w_raddr = r_i + CW'(1);
            ole_pkg::RD_JM1: w_raddr = r_j - CW'(1);
            default:         w_raddr = r_i;
        endcase
    end

    always_comb begin
        w_we = 1'b1;
        case (i_cmd.wr_sel)
            ole_pkg::WR_I_RDATA: begin
                w_waddr = r_i;
                w_wdata = w_rdata;
            end
            ole_pkg::WR_I_INPUT: begin
                w_waddr = r_i;
                w_wdata = {r_hin, r_kin};
            end
            ole_pkg::WR_J_RDATA: begin
                w_waddr = r_j;
                w_wdata = w_rdata;
            end
            ole_pkg::WR_J_TEMP: begin
                w_waddr = r_j;
                w_wdata = {r_th, r_tk};
            end
            default: begin
                w_we    = 1'b0;
                w_waddr = r_i;
                w_wdata = w_rdata;
            end
        endcase
    end

    ole_ram #(
        .WIDTH (ole_pkg::ENTRY_W),
        .DEPTH (ole_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr[ole_pkg::ADDR_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr[ole_pkg::ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_flags.kind       = ole_pkg::t_kind'(r_kind);
        o_flags.pos_ins_ok = (r_pos != '0) && (r_pos <= r_count + CW'(1));
        o_flags.pos_ok     = (r_pos != '0) && (r_pos <= r_count);
        o_flags.full       = (r_count >= CW'(ole_pkg::CAPACITY));
        o_flags.empty      = (r_count == '0);
        o_flags.i_eq_at    = (r_i == r_at);
        o_flags.i_last     = (r_i + CW'(1) >= r_count);
        o_flags.i_ge_cnt   = (r_i >= r_count);
        o_flags.j_zero     = (r_j == '0);
        o_flags.match      = (w_rh == r_hin);
        o_flags.move       = (r_kind == ole_pkg::K_SORT_DOWN) ? (w_rk < r_tk) : (w_rk > r_tk);
        o_flags.out_free   = !r_out_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_hin  <= i_item_handle;
            r_kin  <= i_item_key;
            r_pos  <= w_pos_in;
            r_at   <= n_at;
            r_hout <= '0;
            r_kout <= '0;
            r_fpos <= '0;
            r_st   <= ole_pkg::ST_OK;
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.capture) begin
            r_hout <= w_rh;
            r_kout <= w_rk;
            r_fpos <= r_i + CW'(1);
        end
        if (i_cmd.tmp_load) begin
            r_th <= w_rh;
            r_tk <= w_rk;
        end
        case (i_cmd.i_op)
            ole_pkg::I_SET_AT:    r_i <= r_at;
            ole_pkg::I_SET_COUNT: r_i <= r_count;
            ole_pkg::I_ZERO:      r_i <= '0;
            ole_pkg::I_ONE:       r_i <= CW'(1);
            ole_pkg::I_INC:       r_i <= r_i + CW'(1);
            ole_pkg::I_DEC:       r_i <= r_i - CW'(1);
            default:              r_i <= r_i;
        endcase
        case (i_cmd.j_op)
            ole_pkg::J_SET_I: r_j <= r_i;
            ole_pkg::J_DEC:   r_j <= r_j - CW'(1);
            default:          r_j <= r_j;
        endcase
        if (i_cmd.finish) begin
            o_status         <= r_st;
            o_handle_out     <= r_hout;
            o_key_out        <= r_kout;
            o_found_position <= ole_pkg::POS_BITS'(r_fpos);
            o_entry_count    <= ole_pkg::POS_BITS'(r_count);
            o_is_empty       <= (r_count == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.cnt_op)
                ole_pkg::CNT_INC:  r_count <= r_count + CW'(1);
                ole_pkg::CNT_DEC:  r_count <= r_count - CW'(1);
                ole_pkg::CNT_ZERO: r_count <= '0;
                default:           r_count <= r_count;
            endcase
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

/* rtl/ole_ctrl.sv */
// ----------------------------------------------------------------------------
// ole_ctrl
// Sequencer that steps the datapath through shifts, scans and the sort.
// ----------------------------------------------------------------------------
`default_nettype none

module ole_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire ole_pkg::t_flags i_flags,
    output ole_pkg::t_cmd        o_cmd
);

    ole_pkg::t_state r_state;
    ole_pkg::t_state n_state;

    assign o_stall = (r_state != ole_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ole_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (i_valid) n_state = ole_pkg::S_DECODE;
            end
            ole_pkg::S_DECODE: begin
                case (i_flags.kind)
                    ole_pkg::K_INS_FRONT, ole_pkg::K_INS_BACK, ole_pkg::K_INS_AT: begin
                        if ((i_flags.kind == ole_pkg::K_INS_AT && !i_flags.pos_ins_ok)
                            || i_flags.full) begin
                            n_state = ole_pkg::S_DONE;
                        end else begin
                            n_state = ole_pkg::S_SH_CHK;
                        end
                    end
                    ole_pkg::K_RM_FRONT, ole_pkg::K_RM_BACK:
                        n_state = i_flags.empty ? ole_pkg::S_DONE : ole_pkg::S_RM_RD;
                    ole_pkg::K_RM_AT, ole_pkg::K_GET:
                        n_state = i_flags.pos_ok ? ole_pkg::S_RM_RD : ole_pkg::S_DONE;
                    ole_pkg::K_RM_HANDLE:
                        n_state = i_flags.empty ? ole_pkg::S_DONE : ole_pkg::S_FD_CHK;
                    ole_pkg::K_FIND:
                        n_state = ole_pkg::S_FD_CHK;
                    ole_pkg::K_SORT_UP, ole_pkg::K_SORT_DOWN:
                        n_state = ole_pkg::S_SO_CHK;
                    default:
                        n_state = ole_pkg::S_DONE;
                endcase
            end
            ole_pkg::S_SH_CHK:  n_state = i_flags.i_eq_at ? ole_pkg::S_DONE : ole_pkg::S_SH_WR;
            ole_pkg::S_SH_WR:   n_state = ole_pkg::S_SH_CHK;
            ole_pkg::S_RM_RD:   n_state = ole_pkg::S_RM_CAP;
            ole_pkg::S_RM_CAP: begin
                n_state = (i_flags.kind == ole_pkg::K_GET) ? ole_pkg::S_DONE
                                                            : ole_pkg::S_CL_CHK;
            end
            ole_pkg::S_CL_CHK:  n_state = i_flags.i_last ? ole_pkg::S_DONE : ole_pkg::S_CL_WR;
            ole_pkg::S_CL_WR:   n_state = ole_pkg::S_CL_CHK;
            ole_pkg::S_FD_CHK:  n_state = i_flags.i_ge_cnt ? ole_pkg::S_DONE : ole_pkg::S_FD_CMP;
            ole_pkg::S_FD_CMP: begin
                if (!i_flags.match) begin
                    n_state = ole_pkg::S_FD_CHK;
                end else if (i_flags.kind == ole_pkg::K_RM_HANDLE) begin
                    n_state = ole_pkg::S_CL_CHK;
                end else begin
                    n_state = ole_pkg::S_DONE;
                end
            end
            ole_pkg::S_SO_CHK:  n_state = i_flags.i_ge_cnt ? ole_pkg::S_DONE : ole_pkg::S_SO_TMP;
            ole_pkg::S_SO_TMP:  n_state = ole_pkg::S_SO_JCHK;
            ole_pkg::S_SO_JCHK: n_state = i_flags.j_zero ? ole_pkg::S_SO_CHK : ole_pkg::S_SO_CMP;
            ole_pkg::S_SO_CMP:  n_state = i_flags.move ? ole_pkg::S_SO_JCHK : ole_pkg::S_SO_CHK;
            ole_pkg::S_DONE:    if (i_flags.out_free) n_state = ole_pkg::S_IDLE;
            default:            n_state = ole_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '{load: 1'b0, rd_sel: ole_pkg::RD_NONE, wr_sel: ole_pkg::WR_NONE,
                  i_op: ole_pkg::I_HOLD, j_op: ole_pkg::J_HOLD, cnt_op: ole_pkg::CNT_HOLD,
                  tmp_load: 1'b0, capture: 1'b0, set_st: 1'b0, st: ole_pkg::ST_OK,
                  finish: 1'b0};
        unique case (r_state)
            ole_pkg::S_IDLE: o_cmd.load = i_valid;
            ole_pkg::S_DECODE: begin
                case (i_flags.kind)
                    ole_pkg::K_INS_FRONT, ole_pkg::K_INS_BACK, ole_pkg::K_INS_AT: begin
                        if (i_flags.kind == ole_pkg::K_INS_AT && !i_flags.pos_ins_ok) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ole_pkg::ST_BAD_POS;
                        end else if (i_flags.full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ole_pkg::ST_FULL;
                        end else begin
                            o_cmd.i_op = ole_pkg::I_SET_COUNT;
                        end
                    end
                    ole_pkg::K_RM_FRONT, ole_pkg::K_RM_BACK: begin
                        if (i_flags.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ole_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.i_op = ole_pkg::I_SET_AT;
                        end
                    end
                    ole_pkg::K_RM_AT, ole_pkg::K_GET: begin
                        if (i_flags.pos_ok) begin
                            o_cmd.i_op = ole_pkg::I_SET_AT;
                        end else begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ole_pkg::ST_BAD_POS;
                        end
                    end
                    ole_pkg::K_RM_HANDLE, ole_pkg::K_FIND: begin
                        if (i_flags.kind == ole_pkg::K_RM_HANDLE && i_flags.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ole_pkg::ST_EMPTY;
                        end else begin
                            o_cmd.i_op = ole_pkg::I_ZERO;
                        end
                    end
                    ole_pkg::K_CLEAR:                         o_cmd.cnt_op = ole_pkg::CNT_ZERO;
                    ole_pkg::K_SORT_UP, ole_pkg::K_SORT_DOWN: o_cmd.i_op   = ole_pkg::I_ONE;
                    default: ;
                endcase
            end
            // shift entries up one place, top down, then drop the new one in
            ole_pkg::S_SH_CHK: begin
                if (i_flags.i_eq_at) begin
                    o_cmd.wr_sel = ole_pkg::WR_I_INPUT;
                    o_cmd.cnt_op = ole_pkg::CNT_INC;
                end else begin
                    o_cmd.rd_sel = ole_pkg::RD_IM1;
                end
            end
            ole_pkg::S_SH_WR: begin
                o_cmd.wr_sel = ole_pkg::WR_I_RDATA;
                o_cmd.i_op   = ole_pkg::I_DEC;
            end
            ole_pkg::S_RM_RD:  o_cmd.rd_sel  = ole_pkg::RD_I;
            ole_pkg::S_RM_CAP: o_cmd.capture = 1'b1;
            // close the gap bottom up
            ole_pkg::S_CL_CHK: begin
                if (i_flags.i_last) begin
                    o_cmd.cnt_op = ole_pkg::CNT_DEC;
                end else begin
                    o_cmd.rd_sel = ole_pkg::RD_IP1;
                end
            end
            ole_pkg::S_CL_WR: begin
                o_cmd.wr_sel = ole_pkg::WR_I_RDATA;
                o_cmd.i_op   = ole_pkg::I_INC;
            end
            ole_pkg::S_FD_CHK: begin
                if (i_flags.i_ge_cnt) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ole_pkg::ST_NOT_FOUND;
                end else begin
                    o_cmd.rd_sel = ole_pkg::RD_I;
                end
            end
            ole_pkg::S_FD_CMP: begin
                if (i_flags.match) begin
                    o_cmd.capture = 1'b1;
                end else begin
                    o_cmd.i_op = ole_pkg::I_INC;
                end
            end
            // insertion sort: hold entry i, slide larger keys (smaller ones for sort down) up behind it
            ole_pkg::S_SO_CHK: o_cmd.rd_sel = ole_pkg::RD_I;
            ole_pkg::S_SO_TMP: begin
                o_cmd.tmp_load = 1'b1;
                o_cmd.j_op     = ole_pkg::J_SET_I;
            end
            ole_pkg::S_SO_JCHK: begin
                if (i_flags.j_zero) begin
                    o_cmd.wr_sel = ole_pkg::WR_J_TEMP;
                    o_cmd.i_op   = ole_pkg::I_INC;
                end else begin
                    o_cmd.rd_sel = ole_pkg::RD_JM1;
                end
            end
            ole_pkg::S_SO_CMP: begin
                if (i_flags.move) begin
                    o_cmd.wr_sel = ole_pkg::WR_J_RDATA;
                    o_cmd.j_op   = ole_pkg::J_DEC;
                end else begin
                    o_cmd.wr_sel = ole_pkg::WR_J_TEMP;
                    o_cmd.i_op   = ole_pkg::I_INC;
                end
            end
            ole_pkg::S_DONE: o_cmd.finish = i_flags.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/ordered_list_engine_top.sv */
// ----------------------------------------------------------------------------
// ordered_list_engine_top
// Ordered list of handle and key entries held in one RAM, driven by a sequencer.
// ----------------------------------------------------------------------------
// flow: an item is accepted in idle, decoded, and its result registered on leaving done
//   once the output is free; removes and get read the entry first, and shifts and scans
//   walk the entries, each step a RAM read, then a write or compare, as the read is registered
// throughput: one item at a time, next beat taken the cycle after the result is
//   registered; sort is insertion sort
// reset: synchronous active low, clears count, sequencer and output valid; RAM not cleared
`default_nettype none

module ordered_list_engine_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [3:0]                      i_kind,
    input  wire logic [ole_pkg::HANDLE_BITS-1:0] i_item_handle,
    input  wire logic [ole_pkg::KEY_BITS-1:0]    i_item_key,
    input  wire logic [ole_pkg::POS_BITS-1:0]    i_position,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ole_pkg::ST_BITS-1:0]          o_status,
    output logic [ole_pkg::HANDLE_BITS-1:0]      o_handle_out,
    output logic [ole_pkg::KEY_BITS-1:0]         o_key_out,
    output logic [ole_pkg::POS_BITS-1:0]         o_found_position,
    output logic [ole_pkg::POS_BITS-1:0]         o_entry_count,
    output logic                                 o_is_empty
);

    ole_pkg::t_cmd   w_cmd;
    ole_pkg::t_flags w_flags;

    ole_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_flags (w_flags),
        .o_cmd   (w_cmd)
    );

    ole_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_kind           (i_kind),
        .i_item_handle    (i_item_handle),
        .i_item_key       (i_item_key),
        .i_position       (i_position),
        .i_cmd            (w_cmd),
        .o_flags          (w_flags),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_handle_out     (o_handle_out),
        .o_key_out        (o_key_out),
        .o_found_position (o_found_position),
        .o_entry_count    (o_entry_count),
        .o_is_empty       (o_is_empty)
    );

endmodule

`default_nettype wire
